// ===== rtl/smf_pkg.sv =====
// Package for the sample median finder: item structs and default sizes.
// Used by smf_median and the top module; depends on nothing.
package smf_pkg;

  localparam int CAPACITY_DEF     = 128;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int IN_SAMPLE_W      = 16;
  localparam int OUT_MEDIAN_W     = 16;
  localparam int OUT_COUNT_W      = 8;

  typedef struct packed {
    logic [IN_SAMPLE_W-1:0] sample_value;
    logic                   last_sample;
  } in_item_t;

  typedef struct packed {
    logic [OUT_MEDIAN_W-1:0] median_value;
    logic [OUT_COUNT_W-1:0]  sample_count;
    logic                    overflow_flag;
  } out_item_t;

endpackage

// ===== rtl/smf_cell.sv =====
// One cell of the sorted insertion chain: holds one sample and shifts up
// when a smaller sample is inserted below it. Depends on nothing.
module smf_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    insert_en,
  input  logic                    occupied,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    prev_gt,
  input  logic [SAMPLE_WIDTH-1:0] prev_value,
  output logic                    gt,
  output logic [SAMPLE_WIDTH-1:0] value
);

  logic [SAMPLE_WIDTH-1:0] value_r;
  logic [SAMPLE_WIDTH-1:0] value_nxt;

  assign gt    = !occupied || (value_r > sample);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (insert_en && gt) begin
      value_nxt = prev_gt ? prev_value : sample;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== rtl/smf_median.sv =====
// Median read-out: picks the two middle cells, averages them and holds the
// result in an output register. Depends on smf_pkg.
module smf_median #(
  parameter int CAPACITY     = 128,
  parameter int SAMPLE_WIDTH = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SAMPLE_WIDTH-1:0] cell_vals [CAPACITY],
  input  logic                    pend,
  input  logic [CW-1:0]           fin_count,
  input  logic                    fin_drop,
  output logic                    pend_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output smf_pkg::out_item_t      out_data
);

  import smf_pkg::*;

  logic                    sel_valid_r;
  logic                    sel_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] lo_r;
  logic [SAMPLE_WIDTH-1:0] hi_r;
  logic [CW-1:0]           cnt_r;
  logic                    drop_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_item_t               out_r;
  logic                    out_ready;
  logic [CW-1:0]           half;
  logic [IW-1:0]           hi_idx;
  logic [IW-1:0]           lo_idx;
  logic [SAMPLE_WIDTH:0]   sum;

  assign out_ready  = !out_valid_r || !out_stall;
  assign pend_ready = !sel_valid_r || out_ready;
  assign half       = fin_count >> 1;
  assign hi_idx     = IW'(half);
  assign lo_idx     = fin_count[0] ? IW'(half) : IW'(half - CW'(1));
  assign sum        = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    sel_valid_nxt = sel_valid_r;
    if (pend_ready) begin
      sel_valid_nxt = pend;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = sel_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_valid_r <= sel_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_ready && pend) begin
      lo_r   <= cell_vals[lo_idx];
      hi_r   <= cell_vals[hi_idx];
      cnt_r  <= fin_count;
      drop_r <= fin_drop;
    end
    if (out_ready && sel_valid_r) begin
      out_r.median_value  <= OUT_MEDIAN_W'(sum[SAMPLE_WIDTH:1]);
      out_r.sample_count  <= OUT_COUNT_W'(cnt_r);
      out_r.overflow_flag <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/sample_median_finder_top.sv =====
// Sample median finder: a burst of samples is kept in ascending order in a
// chain of CAPACITY cells, one sample inserted per cycle; the burst's last
// sample triggers the median read-out. Depends on smf_pkg, smf_cell, smf_median.
//
// Samples are taken one per cycle. A transfer that carries last_sample stalls
// the input while the two middle cells are captured; the stall is extended
// only while an earlier result still waits behind out_stall. The pair is then
// averaged into an output register, where the result waits while a new burst
// may already start filling the chain. Samples that arrive with the chain full
// are dropped and reported through overflow_flag.
module sample_median_finder_top #(
  parameter int CAPACITY     = smf_pkg::CAPACITY_DEF,
  parameter int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output smf_pkg::out_item_t out_data
);

  import smf_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic                    drop_r;
  logic                    drop_nxt;
  logic                    pend_r;
  logic                    pend_nxt;
  logic [CW-1:0]           fin_count_r;
  logic                    fin_drop_r;
  logic                    pend_ready;
  logic                    accept;
  logic                    full;
  logic                    insert_en;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    gt   [CAPACITY];
  logic [SAMPLE_WIDTH-1:0] vals [CAPACITY];

  assign in_stall  = pend_r;
  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == CW'(CAPACITY));
  assign insert_en = accept && !full;
  assign sample    = SAMPLE_WIDTH'(in_data.sample_value);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_gt;
    logic [SAMPLE_WIDTH-1:0] prev_value;
    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = sample;
    end else begin : g_body
      assign prev_gt    = gt[i-1];
      assign prev_value = vals[i-1];
    end
    smf_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .insert_en  (insert_en),
      .occupied   (CW'(i) < count_r),
      .sample     (sample),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .gt         (gt[i]),
      .value      (vals[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    pend_nxt  = pend_r;
    if (pend_r && pend_ready) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      if (in_data.last_sample) begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
        pend_nxt  = 1'b1;
      end else if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_sample) begin
      fin_count_r <= full ? count_r : count_r + CW'(1);
      fin_drop_r  <= drop_r || full;
    end
  end

  smf_median #(
    .CAPACITY     (CAPACITY),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_vals  (vals),
    .pend       (pend_r),
    .fin_count  (fin_count_r),
    .fin_drop   (fin_drop_r),
    .pend_ready (pend_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
